>>> rtl/core/sbv_pkg.sv
// Package: constants, types and the CRC-32 byte step for the storage block validator.
package sbv_pkg;

  localparam int unsigned SECTOR_BYTES = 4096;
  localparam int unsigned MAX_SECTORS  = 255;
  localparam int unsigned SPAN_CAP     = SECTOR_BYTES * MAX_SECTORS;
  localparam int unsigned POS_W        = $clog2(SPAN_CAP + 1);
  localparam int unsigned HDR_LEN      = 20;

  localparam logic [POS_W-1:0] HDR_LEN_P  = POS_W'(HDR_LEN);
  localparam logic [POS_W-1:0] SPAN_CAP_P = POS_W'(SPAN_CAP);

  // Header byte offsets at which a field is complete
  localparam logic [POS_W-1:0] POS_MAGIC_END = POS_W'(3);
  localparam logic [POS_W-1:0] POS_RAW_END   = POS_W'(7);
  localparam logic [POS_W-1:0] POS_TYPE      = POS_W'(8);
  localparam logic [POS_W-1:0] POS_PLEN_END  = POS_W'(15);
  localparam logic [POS_W-1:0] POS_CRC_END   = POS_W'(19);

  localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
  localparam logic [31:0] ALL_ONES     = 32'hFFFF_FFFF;
  localparam logic [31:0] MAX_RAW_RST  = 32'h0100_0000;

  typedef enum logic [1:0] {
    CFG_MAGIC   = 2'd0,
    CFG_COMP    = 2'd1,
    CFG_MAX_RAW = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_BAD_MAGIC = 3'd1,
    STAT_BAD_RAW   = 3'd2,
    STAT_BAD_COMP  = 3'd3,
    STAT_OVERRUN   = 3'd4,
    STAT_CRC_ERR   = 3'd5,
    STAT_TRUNC     = 3'd6
  } status_e;

  typedef struct packed {
    logic [31:0] magic;
    logic [7:0]  comp;
    logic [31:0] max_raw;
  } cfg_t;

  typedef struct packed {
    logic [POS_W-1:0] span;
    logic [31:0]      magic;
    logic [31:0]      raw_len;
    logic [7:0]       ctype;
    logic [31:0]      payload_len;
    logic [31:0]      stored_crc;
    logic [31:0]      running_crc;
  } fields_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = {24'd0, crc[7:0] ^ b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c ^ (crc >> 8);
  endfunction

endpackage

>>> rtl/core/sbv_if.sv
// Interfaces: byte input channel and result channel with valid/ready handshake.
interface sbv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface sbv_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] raw_length;
  logic [31:0] payload_length;

  modport source (output valid, output status, output raw_length, output payload_length,
                  input ready);
  modport sink   (input valid, input status, input raw_length, input payload_length,
                  output ready);
endinterface

>>> rtl/core/sbv_block_track.sv
// Per-block state: byte position, header field capture and running CRC.
module sbv_block_track (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic [7:0]       byte_i,
  input  logic             last_i,
  output sbv_pkg::fields_t nxt_o
);

  logic [sbv_pkg::POS_W-1:0] pos_q, pos_d;
  logic [31:0] hs_q, hs_d;
  logic [31:0] magic_q, magic_d;
  logic [31:0] raw_q, raw_d;
  logic [7:0]  type_q, type_d;
  logic [31:0] plen_q, plen_d;
  logic [31:0] stored_q, stored_d;
  logic [31:0] crc_q, crc_d;
  logic [sbv_pkg::POS_W-1:0] pay_off;

  assign pay_off = pos_q - sbv_pkg::HDR_LEN_P;

  always_comb begin
    hs_d     = hs_q;
    magic_d  = magic_q;
    raw_d    = raw_q;
    type_d   = type_q;
    plen_d   = plen_q;
    stored_d = stored_q;
    crc_d    = crc_q;
    if (pos_q < sbv_pkg::HDR_LEN_P) begin
      hs_d = {byte_i, hs_q[31:8]};
      case (pos_q)
        sbv_pkg::POS_MAGIC_END: magic_d  = hs_d;
        sbv_pkg::POS_RAW_END:   raw_d    = hs_d;
        sbv_pkg::POS_TYPE:      type_d   = byte_i;
        sbv_pkg::POS_PLEN_END:  plen_d   = hs_d;
        sbv_pkg::POS_CRC_END:   stored_d = hs_d;
        default: ;
      endcase
    end else if (pos_q < sbv_pkg::SPAN_CAP_P && 32'(pay_off) < plen_q) begin
      crc_d = sbv_pkg::crc_byte(crc_q, byte_i);
    end
    pos_d = (pos_q < sbv_pkg::SPAN_CAP_P) ? pos_q + 1'b1 : pos_q;
  end

  assign nxt_o = '{span: pos_d, magic: magic_d, raw_len: raw_d, ctype: type_d,
                   payload_len: plen_d, stored_crc: stored_d, running_crc: crc_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      hs_q     <= '0;
      magic_q  <= '0;
      raw_q    <= '0;
      type_q   <= '0;
      plen_q   <= '0;
      stored_q <= '0;
      crc_q    <= sbv_pkg::ALL_ONES;
    end else if (adv_i) begin
      if (last_i) begin
        pos_q    <= '0;
        hs_q     <= '0;
        magic_q  <= '0;
        raw_q    <= '0;
        type_q   <= '0;
        plen_q   <= '0;
        stored_q <= '0;
        crc_q    <= sbv_pkg::ALL_ONES;
      end else begin
        pos_q    <= pos_d;
        hs_q     <= hs_d;
        magic_q  <= magic_d;
        raw_q    <= raw_d;
        type_q   <= type_d;
        plen_q   <= plen_d;
        stored_q <= stored_d;
        crc_q    <= crc_d;
      end
    end
  end

endmodule

>>> rtl/core/sbv_status_check.sv
// Block status: first failing check in header-then-payload order.
module sbv_status_check (
  input  sbv_pkg::fields_t fields_i,
  input  sbv_pkg::cfg_t    cfg_i,
  output sbv_pkg::status_e status_o
);

  logic [32:0] need_len;

  assign need_len = 33'(sbv_pkg::HDR_LEN) + {1'b0, fields_i.payload_len};

  always_comb begin
    if (fields_i.span < sbv_pkg::HDR_LEN_P) begin
      status_o = sbv_pkg::STAT_TRUNC;
    end else if (fields_i.magic != cfg_i.magic) begin
      status_o = sbv_pkg::STAT_BAD_MAGIC;
    end else if (fields_i.raw_len == '0 || fields_i.raw_len > cfg_i.max_raw) begin
      status_o = sbv_pkg::STAT_BAD_RAW;
    end else if (fields_i.ctype != cfg_i.comp) begin
      status_o = sbv_pkg::STAT_BAD_COMP;
    end else if (fields_i.payload_len == '0 || need_len > 33'(fields_i.span)) begin
      status_o = sbv_pkg::STAT_OVERRUN;
    end else if ((fields_i.running_crc ^ sbv_pkg::ALL_ONES) != fields_i.stored_crc) begin
      status_o = sbv_pkg::STAT_CRC_ERR;
    end else begin
      status_o = sbv_pkg::STAT_OK;
    end
  end

endmodule

>>> rtl/core/storage_block_validator.sv
// Top level: storage block validator with header capture, payload CRC-32 and status.
//
//  channel   dir   transfer when      payload
//  in_i      in    valid & ready      data_byte[7:0], last_byte
//  res_o     out   valid & ready      status[2:0], raw_length[31:0], payload_length[31:0]
//  cfg       in    cfg_we_i           cfg_idx_i[1:0], cfg_data_i[31:0]
//
// One byte per cycle sustained unless a held result stalls a last byte; a byte reaches
// the block state through the input register, and a result is registered from the last
// byte's block state once that byte leaves the input register. Throughput is set by the
// byte-wide CRC step and the status compare, which are combinational.
// Reset clears the block state, restores register defaults and empties both stages.
// A held result stalls only last bytes; other bytes keep flowing behind it.
module storage_block_validator (
  input  logic         clk_i,
  input  logic         rst_ni,
  sbv_in_if.sink       in_i,
  sbv_res_if.source    res_o,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i
);

  sbv_pkg::cfg_t    cfg_q;
  sbv_pkg::fields_t nxt;
  sbv_pkg::status_e status;

  logic        inq_valid_q;
  logic [7:0]  inq_byte_q;
  logic        inq_last_q;
  logic        adv;

  logic        res_valid_q;
  logic [2:0]  res_status_q;
  logic [31:0] res_raw_q;
  logic [31:0] res_plen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.magic   <= '0;
      cfg_q.comp    <= '0;
      cfg_q.max_raw <= sbv_pkg::MAX_RAW_RST;
    end else if (cfg_we_i) begin
      case (sbv_pkg::cfg_idx_e'(cfg_idx_i))
        sbv_pkg::CFG_MAGIC:   cfg_q.magic   <= cfg_data_i;
        sbv_pkg::CFG_COMP:    cfg_q.comp    <= cfg_data_i[7:0];
        sbv_pkg::CFG_MAX_RAW: cfg_q.max_raw <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign adv        = inq_valid_q && (!inq_last_q || !res_valid_q || res_o.ready);
  assign in_i.ready = !inq_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      inq_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      inq_byte_q <= in_i.data_byte;
      inq_last_q <= in_i.last_byte;
    end
  end

  sbv_block_track u_track (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .byte_i (inq_byte_q),
    .last_i (inq_last_q),
    .nxt_o  (nxt)
  );

  sbv_status_check u_check (
    .fields_i (nxt),
    .cfg_i    (cfg_q),
    .status_o (status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (adv && inq_last_q) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && inq_last_q) begin
      res_status_q <= status;
      res_raw_q    <= nxt.raw_len;
      res_plen_q   <= nxt.payload_len;
    end
  end

  assign res_o.valid          = res_valid_q;
  assign res_o.status         = res_status_q;
  assign res_o.raw_length     = res_raw_q;
  assign res_o.payload_length = res_plen_q;

endmodule

>>> rtl/core/sbv_checker.sv
// Checker: port-level properties of the storage block validator, bound to the top level.
module sbv_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic [2:0]  res_status_i,
  input logic [31:0] res_raw_i,
  input logic [31:0] res_plen_i
);

  localparam logic [31:0] MAX_PLEN = 32'(sbv_pkg::SPAN_CAP - sbv_pkg::HDR_LEN);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_status_i)
      && $stable(res_raw_i) && $stable(res_plen_i))
    else $error("result changed while stalled");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> res_status_i <= sbv_pkg::STAT_TRUNC)
    else $error("status code out of range");

  a_ok_lengths: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_status_i == sbv_pkg::STAT_OK |-> res_raw_i != '0 && res_plen_i != '0)
    else $error("ok status with a zero length");

  a_plen_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (res_status_i == sbv_pkg::STAT_OK || res_status_i == sbv_pkg::STAT_CRC_ERR)
      |-> res_plen_i <= MAX_PLEN)
    else $error("payload checked beyond the largest span");

endmodule

bind storage_block_validator sbv_checker u_sbv_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .res_status_i (res_o.status),
  .res_raw_i    (res_o.raw_length),
  .res_plen_i   (res_o.payload_length)
);
